FILE: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_PAGES   = 1024;
  localparam int ORDER_LIMIT = 10;
  localparam int LVLS        = ORDER_LIMIT + 1;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int ORD_W       = 4;
  localparam int OP_W        = 5;

  localparam logic [CNT_W-1:0] NIL_LINK = CNT_W'(MAX_PAGES);

  // request kinds
  localparam logic [1:0] RQ_INIT  = 2'd0;
  localparam logic [1:0] RQ_ALLOC = 2'd1;
  localparam logic [1:0] RQ_FREE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE   = 5'd0;
  localparam op_t OP_LATCH  = 5'd1;
  localparam op_t OP_DECODE = 5'd2;
  localparam op_t OP_CLR    = 5'd3;
  localparam op_t OP_CARVE  = 5'd4;
  localparam op_t OP_P0     = 5'd5;
  localparam op_t OP_P1     = 5'd6;
  localparam op_t OP_U0     = 5'd7;
  localparam op_t OP_U1     = 5'd8;
  localparam op_t OP_U2     = 5'd9;
  localparam op_t OP_U3     = 5'd10;
  localparam op_t OP_ASRCH  = 5'd11;
  localparam op_t OP_ASPLIT = 5'd12;
  localparam op_t OP_FC0    = 5'd13;
  localparam op_t OP_FC1    = 5'd14;
  localparam op_t OP_FO0    = 5'd15;
  localparam op_t OP_FO1    = 5'd16;
  localparam op_t OP_FM0    = 5'd17;
  localparam op_t OP_FM1    = 5'd18;
  localparam op_t OP_FM2    = 5'd19;
  localparam op_t OP_LOAD   = 5'd20;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] chk;
    logic       clr_last;
    logic       rem_zero;
    logic       push_more;
    logic       lvl_gt_top;
    logic       head_nonnil;
    logic       split_more;
    logic       fc_hit;
    logic       fc_last;
    logic       fo_hit;
    logic       merge_stop;
    logic       fm_nomatch;
    logic       out_busy;
  } sts_t;

  function automatic logic [CNT_W-1:0] pow2(input logic [ORD_W-1:0] o);
    return CNT_W'(1) << o;
  endfunction

  // position of the highest set bit, zero for zero
  function automatic logic [ORD_W-1:0] flog2(input logic [CNT_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (v[k]) r = ORD_W'(k);
    end
    return r;
  endfunction

endpackage

FILE: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output bpa_pkg::cmd_t cmd,
  input  bpa_pkg::sts_t sts
);
  import bpa_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_CARVE  = 5'd3;
  localparam logic [4:0] S_P0     = 5'd4;
  localparam logic [4:0] S_P1     = 5'd5;
  localparam logic [4:0] S_U0     = 5'd6;
  localparam logic [4:0] S_U1     = 5'd7;
  localparam logic [4:0] S_U2     = 5'd8;
  localparam logic [4:0] S_U3     = 5'd9;
  localparam logic [4:0] S_ASRCH  = 5'd10;
  localparam logic [4:0] S_ASPLIT = 5'd11;
  localparam logic [4:0] S_FC0    = 5'd12;
  localparam logic [4:0] S_FC1    = 5'd13;
  localparam logic [4:0] S_FO0    = 5'd14;
  localparam logic [4:0] S_FO1    = 5'd15;
  localparam logic [4:0] S_FM0    = 5'd16;
  localparam logic [4:0] S_FM1    = 5'd17;
  localparam logic [4:0] S_FM2    = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;

  logic [4:0] state, state_next;
  logic [4:0] clr_ret, clr_ret_next;
  logic [4:0] push_ret, push_ret_next;
  logic [4:0] unl_ret, unl_ret_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    clr_ret_next  = clr_ret;
    push_ret_next = push_ret;
    unl_ret_next  = unl_ret;
    cmd.op        = OP_NONE;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = clr_ret;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.op = OP_DECODE;
        if (sts.chk != ST_OK) begin
          state_next = S_FIN;
        end else begin
          case (sts.req_type)
            RQ_INIT: begin
              clr_ret_next = S_CARVE;
              state_next   = S_CLR;
            end
            RQ_ALLOC: state_next = S_ASRCH;
            RQ_FREE:  state_next = S_FC0;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_CARVE: begin
        cmd.op = OP_CARVE;
        if (sts.rem_zero) begin
          state_next = S_FIN;
        end else begin
          push_ret_next = S_CARVE;
          state_next    = S_P0;
        end
      end
      S_P0: begin
        cmd.op     = OP_P0;
        state_next = sts.push_more ? S_P1 : push_ret;
      end
      S_P1: begin
        cmd.op     = OP_P1;
        state_next = push_ret;
      end
      S_U0: begin
        cmd.op     = OP_U0;
        state_next = S_U1;
      end
      S_U1: begin
        cmd.op     = OP_U1;
        state_next = S_U2;
      end
      S_U2: begin
        cmd.op     = OP_U2;
        state_next = S_U3;
      end
      S_U3: begin
        cmd.op     = OP_U3;
        state_next = unl_ret;
      end
      S_ASRCH: begin
        cmd.op = OP_ASRCH;
        if (sts.lvl_gt_top) begin
          state_next = S_FIN;
        end else if (sts.head_nonnil) begin
          unl_ret_next = S_ASPLIT;
          state_next   = S_U0;
        end
      end
      S_ASPLIT: begin
        cmd.op = OP_ASPLIT;
        if (sts.split_more) begin
          push_ret_next = S_ASPLIT;
          state_next    = S_P0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FC0: begin
        cmd.op     = OP_FC0;
        state_next = S_FC1;
      end
      S_FC1: begin
        cmd.op = OP_FC1;
        if (sts.fc_hit) state_next = S_FIN;
        else if (sts.fc_last) state_next = S_FO0;
        else state_next = S_FC0;
      end
      S_FO0: begin
        cmd.op     = OP_FO0;
        state_next = sts.lvl_gt_top ? S_FM0 : S_FO1;
      end
      S_FO1: begin
        cmd.op     = OP_FO1;
        state_next = sts.fo_hit ? S_FIN : S_FO0;
      end
      S_FM0: begin
        cmd.op = OP_FM0;
        if (sts.merge_stop) begin
          push_ret_next = S_FIN;
          state_next    = S_P0;
        end else begin
          state_next = S_FM1;
        end
      end
      S_FM1: begin
        cmd.op = OP_FM1;
        if (sts.fm_nomatch) begin
          push_ret_next = S_FIN;
          state_next    = S_P0;
        end else begin
          unl_ret_next = S_FM2;
          state_next   = S_U0;
        end
      end
      S_FM2: begin
        cmd.op     = OP_FM2;
        state_next = S_FM0;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_ret  <= S_IDLE;
      push_ret <= S_FIN;
      unl_ret  <= S_FIN;
    end else begin
      state    <= state_next;
      clr_ret  <= clr_ret_next;
      push_ret <= push_ret_next;
      unl_ret  <= unl_ret_next;
    end
  end

endmodule

FILE: rtl/bpa_dpath.sv
`timescale 1ns / 1ps
module bpa_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  bpa_pkg::cmd_t               cmd,
  output bpa_pkg::sts_t               sts,
  input  logic [1:0]                  in_type,
  input  logic [bpa_pkg::IDX_W-1:0]   in_idx,
  input  logic [bpa_pkg::CNT_W-1:0]   in_cnt,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [bpa_pkg::IDX_W-1:0]   out_idx,
  output logic [bpa_pkg::ORD_W-1:0]   out_ord,
  output logic [bpa_pkg::CNT_W-1:0]   out_free
);
  import bpa_pkg::*;

  logic [1:0]       req_type;
  logic [IDX_W-1:0] req_idx;
  logic [CNT_W-1:0] req_cnt;
  logic [ORD_W-1:0] ord, lvl, pord, topo;
  logic [IDX_W-1:0] cur, bud, uidx, pidx;
  logic [CNT_W-1:0] lp, ln, hsave, rem, pos, scan, ftot, mgd;
  logic [CNT_W-1:0] heads [LVLS];
  logic [1:0]       res_st;
  logic [IDX_W-1:0] res_idx;
  logic [ORD_W-1:0] res_ord;

  logic             mark_mem [MAX_PAGES];
  logic [ORD_W-1:0] ord_mem  [MAX_PAGES];
  logic [CNT_W-1:0] nxt_mem  [MAX_PAGES];
  logic [CNT_W-1:0] prv_mem  [MAX_PAGES];
  logic             rd_mark;
  logic [ORD_W-1:0] rd_ord;
  logic [CNT_W-1:0] rd_nxt, rd_prv;

  logic [IDX_W-1:0] addr;
  logic             we_mark, we_ord, we_nxt, we_prv, w_mark;
  logic [ORD_W-1:0] w_ord;
  logic [CNT_W-1:0] w_nxt, w_prv;

  logic [ORD_W-1:0] cnt_fl, aord, init_top, rem_fl, carve_o;
  logic             cnt_pow2, misalign;
  logic [CNT_W-1:0] free_end, lvl_pw, half_pw, carve_pw, head_lvl, head_p;
  logic [IDX_W-1:0] bud_c, hmask_addr;
  logic [CNT_W:0]   bud_end;
  logic [1:0]       chk;

  always_comb begin
    cnt_fl   = flog2(req_cnt);
    cnt_pow2 = (req_cnt != '0) && ((req_cnt & (req_cnt - 1'b1)) == '0);
    aord     = (req_cnt <= CNT_W'(1)) ? '0 : flog2(req_cnt - 1'b1) + 1'b1;
    init_top = (cnt_fl > ORD_W'(ORDER_LIMIT)) ? ORD_W'(ORDER_LIMIT) : cnt_fl;
    free_end = CNT_W'(req_idx) + req_cnt;
    misalign = (req_idx & IDX_W'(req_cnt - 1'b1)) != '0;
    rem_fl   = flog2(rem);
    carve_o  = (rem_fl > topo) ? topo : rem_fl;
    carve_pw = pow2(carve_o);
    lvl_pw   = pow2(lvl);
    half_pw  = pow2(lvl - 1'b1);
    bud_c    = cur ^ lvl_pw[IDX_W-1:0];
    bud_end  = (CNT_W+1)'(bud_c) + (CNT_W+1)'(lvl_pw);
    hmask_addr = req_idx & ~IDX_W'(lvl_pw - 1'b1);
    head_lvl = NIL_LINK;
    if (lvl <= ORD_W'(ORDER_LIMIT)) head_lvl = heads[lvl];
    head_p = NIL_LINK;
    if (pord <= ORD_W'(ORDER_LIMIT)) head_p = heads[pord];
  end

  always_comb begin
    chk = ST_OK;
    case (req_type)
      RQ_INIT: begin
        if (req_cnt == '0 || req_cnt > CNT_W'(MAX_PAGES)) chk = ST_BAD;
      end
      RQ_ALLOC: begin
        if (req_cnt == '0) chk = ST_BAD;
        else if (req_cnt > ftot || aord > topo) chk = ST_NOFIT;
      end
      RQ_FREE: begin
        if (!cnt_pow2 || cnt_fl > topo || misalign || free_end > mgd) chk = ST_BAD;
      end
      default: chk = ST_BAD;
    endcase
  end

  always_comb begin
    sts.req_type    = req_type;
    sts.chk         = chk;
    sts.clr_last    = (scan == CNT_W'(MAX_PAGES - 1));
    sts.rem_zero    = (rem == '0);
    sts.push_more   = (head_p != NIL_LINK);
    sts.lvl_gt_top  = (lvl > topo);
    sts.head_nonnil = (head_lvl != NIL_LINK);
    sts.split_more  = (lvl > ord);
    sts.fc_hit      = rd_mark;
    sts.fc_last     = ((scan + 1'b1) == free_end);
    sts.fo_hit      = rd_mark && (rd_ord == lvl);
    sts.merge_stop  = (lvl >= topo) || (bud_end > (CNT_W+1)'(mgd));
    sts.fm_nomatch  = !rd_mark || (rd_ord != lvl);
    sts.out_busy    = out_valid && !out_ready;
  end

  // memory port: one address per cycle, per-field write enables
  always_comb begin
    addr    = scan[IDX_W-1:0];
    we_mark = 1'b0;
    we_ord  = 1'b0;
    we_nxt  = 1'b0;
    we_prv  = 1'b0;
    w_mark  = 1'b0;
    w_ord   = pord;
    w_nxt   = ln;
    w_prv   = lp;
    case (cmd.op)
      OP_CLR: we_mark = 1'b1;
      OP_P0: begin
        addr    = pidx;
        we_mark = 1'b1;
        we_ord  = 1'b1;
        we_nxt  = 1'b1;
        we_prv  = 1'b1;
        w_mark  = 1'b1;
        w_nxt   = head_p;
        w_prv   = NIL_LINK;
      end
      OP_P1: begin
        addr   = hsave[IDX_W-1:0];
        we_prv = 1'b1;
        w_prv  = CNT_W'(pidx);
      end
      OP_U0: addr = uidx;
      OP_U1: begin
        addr    = uidx;
        we_mark = 1'b1;
      end
      OP_U2: begin
        addr   = lp[IDX_W-1:0];
        we_nxt = (lp != NIL_LINK);
      end
      OP_U3: begin
        addr   = ln[IDX_W-1:0];
        we_prv = (ln != NIL_LINK);
      end
      OP_FO0:  addr = hmask_addr;
      OP_FM0:  addr = bud_c;
      default: addr = scan[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_mark) mark_mem[addr] <= w_mark;
    if (we_ord)  ord_mem[addr]  <= w_ord;
    if (we_nxt)  nxt_mem[addr]  <= w_nxt;
    if (we_prv)  prv_mem[addr]  <= w_prv;
    rd_mark <= mark_mem[addr];
    rd_ord  <= ord_mem[addr];
    rd_nxt  <= nxt_mem[addr];
    rd_prv  <= prv_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LVLS; k++) heads[k] <= NIL_LINK;
      ftot      <= '0;
      topo      <= '0;
      mgd       <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_LATCH: begin
          req_type <= in_type;
          req_idx  <= in_idx;
          req_cnt  <= in_cnt;
        end
        OP_DECODE: begin
          res_st  <= chk;
          res_idx <= '0;
          res_ord <= '0;
          if (chk == ST_OK) begin
            case (req_type)
              RQ_INIT: begin
                for (int k = 0; k < LVLS; k++) heads[k] <= NIL_LINK;
                ftot <= '0;
                topo <= init_top;
                mgd  <= req_cnt;
                rem  <= req_cnt;
                pos  <= '0;
                scan <= '0;
              end
              RQ_ALLOC: begin
                lvl <= aord;
                ord <= aord;
              end
              RQ_FREE: begin
                ord  <= cnt_fl;
                lvl  <= cnt_fl + 1'b1;
                scan <= CNT_W'(req_idx);
              end
              default: ;
            endcase
          end
        end
        OP_CLR: scan <= scan + 1'b1;
        OP_CARVE: begin
          if (rem != '0) begin
            pidx <= pos[IDX_W-1:0];
            pord <= carve_o;
            rem  <= rem - carve_pw;
            pos  <= pos + carve_pw;
            ftot <= ftot + carve_pw;
          end
        end
        OP_P0: begin
          hsave       <= head_p;
          heads[pord] <= CNT_W'(pidx);
        end
        OP_U1: begin
          lp <= rd_prv;
          ln <= rd_nxt;
        end
        OP_U2: begin
          if (lp == NIL_LINK) heads[lvl] <= ln;
        end
        OP_ASRCH: begin
          if (lvl > topo) begin
            res_st <= ST_NOFIT;
          end else if (head_lvl != NIL_LINK) begin
            uidx <= head_lvl[IDX_W-1:0];
            cur  <= head_lvl[IDX_W-1:0];
            ftot <= ftot - lvl_pw;
          end else begin
            lvl <= lvl + 1'b1;
          end
        end
        OP_ASPLIT: begin
          if (lvl > ord) begin
            lvl  <= lvl - 1'b1;
            pord <= lvl - 1'b1;
            pidx <= cur + half_pw[IDX_W-1:0];
            ftot <= ftot + half_pw;
          end else begin
            res_idx <= cur;
            res_ord <= ord;
          end
        end
        OP_FC1: begin
          if (rd_mark) res_st <= ST_BAD;
          else scan <= scan + 1'b1;
        end
        OP_FO0: begin
          if (lvl > topo) begin
            cur  <= req_idx;
            lvl  <= ord;
            ftot <= ftot + req_cnt;
          end
        end
        OP_FO1: begin
          if (rd_mark && rd_ord == lvl) res_st <= ST_BAD;
          else lvl <= lvl + 1'b1;
        end
        OP_FM0: begin
          bud  <= bud_c;
          pord <= lvl;
          pidx <= cur;
        end
        OP_FM1: uidx <= bud;
        OP_FM2: begin
          if (bud < cur) cur <= bud;
          lvl <= lvl + 1'b1;
        end
        OP_LOAD: begin
          out_status <= res_st;
          out_idx    <= res_idx;
          out_ord    <= res_ord;
          out_free   <= ftot;
        end
        default: ;
      endcase
    end
  end

  a_free_le_managed: assert property (@(posedge clk) disable iff (rst)
    ftot <= mgd) else $error("free total exceeds managed pages");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    topo <= ORD_W'(ORDER_LIMIT)) else $error("top order out of range");

  a_upper_list_empty: assert property (@(posedge clk) disable iff (rst)
    (topo < ORD_W'(ORDER_LIMIT)) |-> (heads[ORDER_LIMIT] == NIL_LINK))
    else $error("list above top order is not empty");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOFIT ||
                   out_status == ST_BAD))
    else $error("bad result status code");

endmodule

FILE: rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// Steps, accept to result valid: malformed requests go straight to the result; alloc
// searches up to 11 levels, unlinks, then splits level by level; free scans every page for
// overlap, checks each higher order, merges level by level, then does the final push.
// Init: a pass over all 1024 entries clears the free marks, then each carved block is pushed.
// One request at a time; the next item is taken the cycle after the result is loaded.
// Reset: the same clearing pass over all 1024 entries runs first; s_axis_tready stays low meanwhile.
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] page_index, [20:10] page_count_req
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] block_index, [13:10] block_order,
                                      // [24:14] free page total
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import bpa_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] out_idx;
  logic [ORD_W-1:0] out_ord;
  logic [CNT_W-1:0] out_free;

  // Sequencer: walks the init carve, list search, split, overlap scan and merge steps.
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: list heads, block memories (mark, order, links) and the result register.
  bpa_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_type    (s_axis_tuser),
    .in_idx     (s_axis_tdata[IDX_W-1:0]),
    .in_cnt     (s_axis_tdata[IDX_W+CNT_W-1:IDX_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_idx    (out_idx),
    .out_ord    (out_ord),
    .out_free   (out_free)
  );

  // Pack the result fields lowest first; pad to whole bytes.
  assign m_axis_tdata = {7'b0, out_free, out_ord, out_idx};

endmodule
